// ===== sv/mmd_pkg.sv =====
// ----------------------------------------------------------------------------
// mmd_pkg: shared types, constants and lookup functions
// Character codes, Morse symbol table, command and event types used by the
// front, queue and back parts of the Morse message decoder.
// ----------------------------------------------------------------------------
package mmd_pkg;

  // Field widths
  localparam int CharW  = 8;
  localparam int KindW  = 2;
  localparam int PosW   = 5;

  // Symbol pattern limits
  localparam int MaxMarks = 5;
  localparam int PatW     = MaxMarks;
  localparam int CntW     = $clog2(MaxMarks + 1);

  // Text limit (letter count fits the position field)
  localparam logic [PosW-1:0] TextLimit = PosW'(31);

  // Clear command word
  localparam int ClearLen = 5;
  localparam int ProgW    = $clog2(ClearLen + 1);

  // Character codes
  localparam logic [CharW-1:0] CharDot     = 8'h2E;
  localparam logic [CharW-1:0] CharDash    = 8'h2D;
  localparam logic [CharW-1:0] CharSpace   = 8'h20;
  localparam logic [CharW-1:0] CharUnknown = 8'h3F;
  localparam logic [CharW-1:0] CharA       = 8'h41;

  // Result event kinds
  typedef enum logic [KindW-1:0] {
    EV_LETTER  = 2'd0,
    EV_CLEARED = 2'd1,
    EV_DROPPED = 2'd2
  } event_kind_e;

  // Commands handed from front to back
  typedef enum logic {
    CMD_CLOSE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [PatW-1:0]   pattern;
    logic [CntW-1:0]   count;
  } cmd_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Morse table A-Z: bit i is mark i, 1 = dash
  localparam int NumSyms = 26;
  localparam logic [PatW-1:0] SymPat [NumSyms] = '{
    5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, 5'b00011,
    5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, 5'b00011, 5'b00001,
    5'b00111, 5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, 5'b00100,
    5'b01000, 5'b00110, 5'b01001, 5'b01101, 5'b00011
  };
  localparam logic [CntW-1:0] SymLen [NumSyms] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
    3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2,
    3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3,
    3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // Match a closed symbol against the table, '?' when unknown
  function automatic logic [CharW-1:0] lookup_symbol(input logic [PatW-1:0] pat,
                                                     input logic [CntW-1:0] cnt);
    logic [CharW-1:0] code;
    code = CharUnknown;
    for (int k = 0; k < NumSyms; k++) begin
      if (pat == SymPat[k] && cnt == SymLen[k]) begin
        code = CharA + CharW'(k);
      end
    end
    return code;
  endfunction

  // Characters of the clear word in order
  function automatic logic [CharW-1:0] clear_char(input logic [ProgW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h43;  // C
      3'd1:    c = 8'h4C;  // L
      3'd2:    c = 8'h45;  // E
      3'd3:    c = 8'h41;  // A
      3'd4:    c = 8'h52;  // R
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/mmd_front.sv =====
// ----------------------------------------------------------------------------
// mmd_front: character classifier
// Accepts message characters, builds the pending mark pattern, tracks the
// clear word comparison and pushes close or clear commands to the queue.
// ----------------------------------------------------------------------------
module mmd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mmd_pkg::CharW-1:0] char_code_i,
  input  logic                      end_of_message_i,
  input  mmd_pkg::q_status_t        q_status_i,
  output logic                      push_o,
  output mmd_pkg::cmd_t             push_cmd_o
);
  import mmd_pkg::*;

  logic [PatW-1:0]  pat_q, pat_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProgW-1:0] prog_q, prog_d;
  logic             mism_q, mism_d;
  logic             accept;
  logic             emit;
  logic             match_ok;
  cmd_t             cmd;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Next per-message state and command
  always_comb begin
    pat_d  = pat_q;
    cnt_d  = cnt_q;
    prog_d = prog_q;
    mism_d = mism_q;
    emit   = 1'b0;
    cmd    = '{kind: CMD_CLOSE, pattern: pat_q, count: cnt_q};

    // clear word comparison
    match_ok = !mism_q && (prog_q < ProgW'(ClearLen)) && (char_code_i == clear_char(prog_q));
    if (match_ok) begin
      prog_d = prog_q + 1'b1;
    end else begin
      mism_d = 1'b1;
    end

    // marks and symbol close on space
    if (char_code_i == CharDot || char_code_i == CharDash) begin
      if (cnt_q < CntW'(MaxMarks)) begin
        if (char_code_i == CharDash) begin
          pat_d[cnt_q] = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
      end
    end else if (char_code_i == CharSpace) begin
      if (cnt_q != '0) begin
        emit = 1'b1;
      end
      pat_d = '0;
      cnt_d = '0;
    end

    // message end: clear word or final close, then restart
    if (end_of_message_i) begin
      if (!mism_d && prog_d == ProgW'(ClearLen)) begin
        emit = 1'b1;
        cmd  = '{kind: CMD_CLEAR, pattern: '0, count: '0};
      end else if (!emit && cnt_d != '0) begin
        emit = 1'b1;
        cmd  = '{kind: CMD_CLOSE, pattern: pat_d, count: cnt_d};
      end
      pat_d  = '0;
      cnt_d  = '0;
      prog_d = '0;
      mism_d = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      cnt_q  <= '0;
      prog_q <= '0;
      mism_q <= 1'b0;
    end else if (accept) begin
      pat_q  <= pat_d;
      cnt_q  <= cnt_d;
      prog_q <= prog_d;
      mism_q <= mism_d;
    end
  end

  assign push_o     = accept && emit;
  assign push_cmd_o = cmd;

endmodule

// ===== sv/mmd_queue.sv =====
// ----------------------------------------------------------------------------
// mmd_queue: two-entry command queue
// Decouples the classifier from the decode and output stage.
// ----------------------------------------------------------------------------
module mmd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mmd_pkg::cmd_t      push_cmd_i,
  input  logic               pop_i,
  output mmd_pkg::cmd_t      pop_cmd_o,
  output mmd_pkg::q_status_t status_o
);
  import mmd_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_cmd_o      = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/mmd_back.sv =====
// ----------------------------------------------------------------------------
// mmd_back: symbol decode and text count
// Pops commands, looks up the Morse table, keeps the letter count and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module mmd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mmd_pkg::q_status_t        q_status_i,
  input  mmd_pkg::cmd_t             cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mmd_pkg::event_kind_e      event_kind_o,
  output logic [mmd_pkg::CharW-1:0] letter_code_o,
  output logic [mmd_pkg::PosW-1:0]  text_position_o
);
  import mmd_pkg::*;

  logic                valid_q;
  logic [PosW-1:0]     letters_q, letters_d;
  event_kind_e         kind_q, kind_d;
  logic [CharW-1:0]    code_q, code_d;
  logic [PosW-1:0]     pos_q, pos_d;

  // Take a command whenever the output register is free or drains
  assign pop_o = !q_status_i.empty && (!valid_q || out_ready_i);

  // Result and count for the head command
  always_comb begin
    letters_d = letters_q;
    kind_d    = EV_CLEARED;
    code_d    = '0;
    pos_d     = '0;
    unique case (cmd_i.kind)
      CMD_CLEAR: begin
        letters_d = '0;
      end
      CMD_CLOSE: begin
        code_d = lookup_symbol(cmd_i.pattern, cmd_i.count);
        pos_d  = letters_q;
        if (letters_q < TextLimit) begin
          kind_d    = EV_LETTER;
          letters_d = letters_q + 1'b1;
        end else begin
          kind_d = EV_DROPPED;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      letters_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q   <= 1'b1;
        letters_q <= letters_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= kind_d;
      code_q <= code_d;
      pos_q  <= pos_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign event_kind_o    = kind_q;
  assign letter_code_o   = code_q;
  assign text_position_o = pos_q;

endmodule

// ===== sv/morse_message_decoder_core.sv =====
// A result passes the command queue entry and then the output register before tvalid rises.
// Throughput: one character per cycle while the queue is not full; results leave at
// one per cycle while the queue holds commands and tready is high.
// A two-entry command queue lets input and output stall independently.
// Reset (rst_ni low, asynchronous) empties the queue and output register
// and clears the pending symbol, clear-word match and letter count.
// ----------------------------------------------------------------------------
// morse_message_decoder_core: Morse message decoder top level
// Decodes dot/dash character streams into letters with a bounded text count
// and a whole-message clear command.
// ----------------------------------------------------------------------------
module morse_message_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] letter_code, [12:8] text_position, pad
  output logic [1:0]  m_axis_tuser_o    // [1:0] event_kind
);
  import mmd_pkg::*;

  logic             push;
  cmd_t             push_cmd;
  logic             pop;
  cmd_t             pop_cmd;
  q_status_t        q_status;
  event_kind_e      event_kind;
  logic [CharW-1:0] letter_code;
  logic [PosW-1:0]  text_position;

  // Classifier
  mmd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .char_code_i      (s_axis_tdata_i),
    .end_of_message_i (s_axis_tlast_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_cmd_o       (push_cmd)
  );

  // Command queue
  mmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .status_o   (q_status)
  );

  // Decode and output register
  mmd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .event_kind_o    (event_kind),
    .letter_code_o   (letter_code),
    .text_position_o (text_position)
  );

  // Output packing
  assign m_axis_tdata_o = {3'b000, text_position, letter_code};
  assign m_axis_tuser_o = event_kind;

endmodule

// ===== tb/morse_message_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// morse_message_decoder_core_test: stream-level test of the Morse decoder
// Sends dot/dash/space messages, clear commands and stray bytes through the
// input stream under several idle/stall mixes. A behavioral decoder in the
// testbench predicts every letter, drop and clear event, and each output
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module morse_message_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mmd_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int MaxReports    = 10;
  localparam int DrainCycles   = 8;

  // One decoder event as seen on the output stream
  typedef struct {
    event_kind_e       kind;
    logic [CharW-1:0]  letter;
    logic [PosW-1:0]   pos;
  } decoder_event_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_tvalid        = 1'b0;
  logic [7:0]        s_tdata         = '0;
  logic              s_tlast         = 1'b0;
  logic              m_tready        = 1'b0;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [15:0]       m_axis_tdata_o;
  logic [1:0]        m_axis_tuser_o;

  // Decoder shadow state
  logic [PatW-1:0]   mark_pat;
  int                mark_cnt;
  int                letters_held;
  int                clear_prog;
  bit                clear_broken;

  decoder_event_t    expected_events[$];
  int                mismatch_count = 0;
  int                chars_sent     = 0;
  int                idle_cycles    = 0;
  int                src_idle_pct   = 0;
  int                sink_stall_pct = 0;

  morse_message_decoder_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // Morse table, bit i = mark i, 1 = dash
  function automatic logic [CharW-1:0] morse_letter(input logic [PatW-1:0] pat,
                                                    input int cnt);
    logic [CharW-1:0] letter;
    letter = CharUnknown;
    case ({3'(cnt), pat})
      {3'd2, 5'b00010}: letter = "A";
      {3'd4, 5'b00001}: letter = "B";
      {3'd4, 5'b00101}: letter = "C";
      {3'd3, 5'b00001}: letter = "D";
      {3'd1, 5'b00000}: letter = "E";
      {3'd4, 5'b00100}: letter = "F";
      {3'd3, 5'b00011}: letter = "G";
      {3'd4, 5'b00000}: letter = "H";
      {3'd2, 5'b00000}: letter = "I";
      {3'd4, 5'b01110}: letter = "J";
      {3'd3, 5'b00101}: letter = "K";
      {3'd4, 5'b00010}: letter = "L";
      {3'd2, 5'b00011}: letter = "M";
      {3'd2, 5'b00001}: letter = "N";
      {3'd3, 5'b00111}: letter = "O";
      {3'd4, 5'b00110}: letter = "P";
      {3'd4, 5'b01011}: letter = "Q";
      {3'd3, 5'b00010}: letter = "R";
      {3'd3, 5'b00000}: letter = "S";
      {3'd1, 5'b00001}: letter = "T";
      {3'd3, 5'b00100}: letter = "U";
      {3'd4, 5'b01000}: letter = "V";
      {3'd3, 5'b00110}: letter = "W";
      {3'd4, 5'b01001}: letter = "X";
      {3'd4, 5'b01101}: letter = "Y";
      {3'd4, 5'b00011}: letter = "Z";
      default:          letter = CharUnknown;
    endcase
    return letter;
  endfunction

  function automatic logic [CharW-1:0] clear_word_char(input int idx);
    logic [CharW-1:0] c;
    case (idx)
      0:       c = "C";
      1:       c = "L";
      2:       c = "E";
      3:       c = "A";
      4:       c = "R";
      default: c = '0;
    endcase
    return c;
  endfunction

  // Close the pending symbol; returns 1 when it yields an event
  function automatic bit close_symbol(output decoder_event_t ev);
    if (mark_cnt == 0) return 1'b0;
    ev.letter = morse_letter(mark_pat, mark_cnt);
    ev.pos    = PosW'(letters_held);
    if (letters_held < int'(TextLimit)) begin
      ev.kind = EV_LETTER;
      letters_held++;
    end else begin
      ev.kind = EV_DROPPED;
    end
    mark_pat = '0;
    mark_cnt = 0;
    return 1'b1;
  endfunction

  // Advance the shadow decoder by one accepted character
  task automatic decode_char(input logic [7:0] ch, input logic last);
    decoder_event_t ev;
    bit             have;
    have = 1'b0;
    if (!clear_broken && clear_prog < ClearLen && ch == clear_word_char(clear_prog)) begin
      clear_prog++;
    end else begin
      clear_broken = 1'b1;
    end
    if (ch == CharDot || ch == CharDash) begin
      if (mark_cnt < MaxMarks) begin
        if (ch == CharDash) mark_pat[mark_cnt] = 1'b1;
        mark_cnt++;
      end
    end else if (ch == CharSpace) begin
      have = close_symbol(ev);
    end
    if (last) begin
      if (!clear_broken && clear_prog == ClearLen) begin
        letters_held = 0;
        ev.kind   = EV_CLEARED;
        ev.letter = '0;
        ev.pos    = '0;
        have      = 1'b1;
      end else if (!have) begin
        have = close_symbol(ev);
      end
      mark_pat     = '0;
      mark_cnt     = 0;
      clear_prog   = 0;
      clear_broken = 1'b0;
    end
    if (have) expected_events.push_back(ev);
  endtask

  // Present one character and hold it until the transfer
  task automatic send_char(input logic [7:0] ch, input logic last);
    bit taken;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      if (taken) decode_char(ch, last);
      @(posedge clk_i);
    end while (!taken);
    chars_sent++;
  endtask

  // Hold off the input until every predicted event has come out
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_events.size() != 0);
  endtask

  // Random dots and dashes split into symbols, closed by spaces or the end
  task automatic send_letters_message();
    int nlet;
    int nm;
    bit close_by_end;
    bit end_here;
    nlet         = $urandom_range(1, 4);
    close_by_end = $urandom_range(0, 1);
    for (int i = 0; i < nlet; i++) begin
      nm = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      for (int j = 0; j < nm; j++) begin
        if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)), 1'b0);
        end_here = (i == nlet - 1) && (j == nm - 1) && close_by_end;
        send_char($urandom_range(0, 1) ? CharDash : CharDot, end_here);
      end
      if (!(i == nlet - 1 && close_by_end)) begin
        if ($urandom_range(0, 7) == 0) send_char(CharSpace, 1'b0);
        send_char(CharSpace, i == nlet - 1);
      end
    end
  endtask

  // Exact, corrupted, truncated or overlong clear command
  task automatic send_clear_message();
    logic [7:0] word [6];
    int         len;
    for (int i = 0; i < 5; i++) word[i] = clear_word_char(i);
    word[5] = 8'($urandom_range(0, 255));
    len = 5;
    case ($urandom_range(0, 5))
      3:       word[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
      4:       len = $urandom_range(1, 4);
      5:       len = 6;
      default: ;
    endcase
    for (int i = 0; i < len; i++) send_char(word[i], i == len - 1);
  endtask

  task automatic send_noise_message();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Extremes and each special case, no idling
  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_char(CharDot, 1'b1);                      // single mark closed by message end
    send_char(CharDash, 1'b0);
    send_char(CharSpace, 1'b0);
    send_char(CharSpace, 1'b0);                    // empty symbol, nothing out
    send_char(8'h00, 1'b0);                        // NUL ignored
    send_char(8'hFF, 1'b0);
    for (int i = 0; i < 6; i++) send_char(CharDash, 1'b0);  // marks past the limit dropped
    send_char(CharSpace, 1'b1);
    send_char(CharSpace, 1'b1);                    // end with nothing pending
    for (int i = 0; i < 5; i++) send_char(clear_word_char(i), i == 4);
    send_char(CharDot, 1'b0);
    send_char(CharDash, 1'b1);
    send_char(CharDot, 1'b0);                      // four marks with no letter
    send_char(CharDot, 1'b0);
    send_char(CharDash, 1'b0);
    send_char(CharDash, 1'b1);
    wait_for_results();
  endtask

  // Mostly well-formed messages with random content, some clears and noise
  task automatic test_random_traffic(input int budget, input int src_pct,
                                     input int sink_pct);
    int first;
    int msgs;
    int pick;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    first = chars_sent;
    msgs  = 0;
    while (chars_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_letters_message();
      end else if (pick < 77) begin
        send_clear_message();
      end else begin
        send_noise_message();
      end
      msgs++;
      if (msgs % 40 == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Output stall pattern
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Check each output transfer against the oldest prediction
  always @(negedge clk_i) begin
    decoder_event_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected event: kind %0d letter %h pos %0d",
                   m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[12:8]);
        end
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tuser_o !== want.kind || m_axis_tdata_o[7:0] !== want.letter ||
            m_axis_tdata_o[12:8] !== want.pos) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("event mismatch: expected kind %0d letter %h pos %0d, got kind %0d letter %h pos %0d",
                     want.kind, want.letter, want.pos,
                     m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[12:8]);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    mark_pat     = '0;
    mark_cnt     = 0;
    letters_held = 0;
    clear_prog   = 0;
    clear_broken = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(280, 0, 0);
    test_random_traffic(280, 84, 0);
    test_random_traffic(280, 0, 84);
    test_random_traffic(280, 25, 25);
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
